FILE: rtl/lfys_pkg.sv
// Shared types and constants for the LCG Fisher-Yates shuffler.
// Depends on nothing; every other file but lfys_ram imports it.
`timescale 1ns / 1ps

package lfys_pkg;

  localparam int unsigned ENTRY_W = 12;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned SEED_W  = 32;

  localparam logic [SEED_W-1:0]  LCG_MUL = 32'd1664525;
  localparam logic [SEED_W-1:0]  LCG_ADD = 32'd1013904223;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

  // remainder unit retires one dividend bit per cycle
  localparam int unsigned REM_STEPS   = SEED_W;
  localparam int unsigned REM_STEPS_W = $clog2(REM_STEPS);

  localparam logic ACT_SHUFFLE  = 1'b0;
  localparam logic ACT_READ     = 1'b1;
  localparam logic KIND_SHUFFLE = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SEED_W-1:0] seed;
    logic [11:0]       position;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [ENTRY_W-1:0] entry_value;
  } out_t;

  typedef enum logic [1:0] {
    ASEL_I,
    ASEL_J,
    ASEL_POS
  } addr_sel_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_RD_CAP,
    ST_LCG,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RD_I,
    ST_RD_J,
    ST_CAP_B,
    ST_WR_I,
    ST_WR_J,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic      clr_we;
    logic      load_item;
    logic      lcg_step;
    logic      div_start;
    logic      rd_en;
    logic      wr_en;
    addr_sel_e addr_sel;
    logic      cap_a;
    logic      cap_b;
    logic      dec_i;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic action;
    logic i_zero;
    logic i_one;
    logic rem_done;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/lcg_fisher_yates_shuffler_core.sv
// LCG-driven Fisher-Yates shuffler: top level joining controller and datapath.
// Depends on lfys_pkg, lfys_ctrl, lfys_datapath (lfys_ram, lfys_rem below it).
//
// Input words (in_valid_i / in_ready_o, in_data_i) are either a shuffle
// (action 0, seed) or a read of one permutation entry (action 1, position).
// Every input word yields exactly one output word (out_valid_o / out_ready_i,
// out_data_o): kind 0 with entry_value 0 after a shuffle, kind 1 with the
// entry after a read. Positions at or beyond DEPTH read 0. Write entry_count
// through cfg_we_i / cfg_wdata_i only while no word is in work.
//
// One word is in work at a time. A read goes from acceptance through a RAM
// read and a capture to the output register; a shuffle over n entries (n
// saturated to DEPTH) runs n - 1 swap passes, none for n below 2. Each swap
// pass makes a generator step, starts the divider, waits on the remainder
// unit, one dividend bit per cycle, then makes two RAM reads, a capture and
// two RAM writes. The next word can be taken in the cycle after a result is loaded.
//
// After reset the block sweeps the RAM to the identity, one entry per cycle,
// over all DEPTH entries; in_ready_o stays low meanwhile. The output register
// holds a finished word until it is taken; the next input word is accepted
// meanwhile, and its result waits for the register.
`timescale 1ns / 1ps

module lcg_fisher_yates_shuffler_core
  import lfys_pkg::*;
#(
  parameter int unsigned DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  // sequence the clearing pass and the swap passes
  lfys_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // hold the store, the generator and the output word
  lfys_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/lfys_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lfys_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lfys_rem.sv
// Iterative unsigned remainder, one dividend bit per cycle (restoring).
// Depends on lfys_pkg.
`timescale 1ns / 1ps

module lfys_rem
  import lfys_pkg::*;
#(
  parameter int unsigned DIV_W = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SEED_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  rem_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [REM_STEPS_W-1:0] cnt_q, cnt_d;
  logic [SEED_W-1:0]      shf_q, shf_d;
  logic [DIV_W-1:0]       dvs_q, dvs_d;
  logic [DIV_W-1:0]       rem_q, rem_d;
  logic [DIV_W:0]         trial;

  assign trial = {rem_q, shf_q[SEED_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    shf_d  = shf_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      shf_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      shf_d = {shf_q[SEED_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DIV_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[DIV_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == REM_STEPS_W'(REM_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/lfys_datapath.sv
// Datapath: count register, generator, pass index, swap registers,
// permutation RAM, remainder unit and output register. Depends on lfys_pkg.
`timescale 1ns / 1ps

module lfys_datapath
  import lfys_pkg::*;
#(
  parameter int unsigned DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  in_t                in_data_i,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DIV_W = AW + 1;

  logic [COUNT_W-1:0] count_q;
  logic [SEED_W-1:0]  gen_q;
  logic               action_q;
  logic [11:0]        pos_q;
  logic               pos_ok_q;
  logic [AW-1:0]      i_q;
  logic [AW-1:0]      clr_addr_q;
  logic [ENTRY_W-1:0] a_q, b_q;
  logic               out_valid_q;
  out_t               out_q;

  logic [31:0]        n_sat;
  logic [AW-1:0]      i_init;
  logic [SEED_W-1:0]  gen_next;
  logic               rem_done;
  logic [DIV_W-1:0]   rem;
  logic [AW-1:0]      j;
  logic [AW-1:0]      addr;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // saturate the count to the store depth; fewer than two entries means no pass
  assign n_sat  = (32'(count_q) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(count_q);
  assign i_init = (n_sat < 32'd2) ? '0 : AW'(n_sat - 32'd1);

  assign gen_next = gen_q * LCG_MUL + LCG_ADD;
  assign j        = rem[AW-1:0];

  always_comb begin
    unique case (cmd_i.addr_sel)
      ASEL_I:   addr = i_q;
      ASEL_J:   addr = j;
      ASEL_POS: addr = AW'(pos_q);
      default:  addr = i_q;
    endcase
  end

  always_comb begin
    ram_we    = cmd_i.clr_we | cmd_i.wr_en;
    ram_waddr = addr;
    ram_wdata = (cmd_i.addr_sel == ASEL_I) ? b_q : a_q;
    if (cmd_i.clr_we) begin
      ram_waddr = clr_addr_q;
      ram_wdata = ENTRY_W'(clr_addr_q);
    end
  end

  lfys_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  lfys_rem #(
    .DIV_W (DIV_W)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (gen_q),
    .divisor_i  ({1'b0, i_q} + DIV_W'(1)),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= COUNT_RESET;
      gen_q       <= '0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (cmd_i.load_item && in_data_i.action == ACT_SHUFFLE) begin
        gen_q <= in_data_i.seed;
      end else if (cmd_i.lcg_step) begin
        gen_q <= gen_next;
      end
      if (cmd_i.clr_we) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q <= in_data_i.action;
      pos_q    <= in_data_i.position;
      pos_ok_q <= 32'(in_data_i.position) < 32'(DEPTH);
      i_q      <= i_init;
    end else if (cmd_i.dec_i) begin
      i_q <= i_q - 1'b1;
    end
    if (cmd_i.cap_a) begin
      a_q <= ram_rdata;
    end
    if (cmd_i.cap_b) begin
      b_q <= ram_rdata;
    end
    if (cmd_i.load_out) begin
      out_q.kind        <= (action_q == ACT_READ) ? KIND_READ : KIND_SHUFFLE;
      out_q.entry_value <= (action_q == ACT_READ && pos_ok_q) ? b_q : '0;
    end
  end

  assign status_o.clear_last = (clr_addr_q == AW'(DEPTH - 1));
  assign status_o.action     = action_q;
  assign status_o.i_zero     = (i_q == '0);
  assign status_o.i_one      = (i_q == AW'(1));
  assign status_o.rem_done   = rem_done;
  assign status_o.out_busy   = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/lfys_ctrl.sv
// Controller state machine: clearing pass, item intake, swap-pass sequencing.
// Depends on lfys_pkg.
`timescale 1ns / 1ps

module lfys_ctrl
  import lfys_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.addr_sel = ASEL_I;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (status_i.action == ACT_READ) begin
          cmd_o.addr_sel = ASEL_POS;
          cmd_o.rd_en    = 1'b1;
          state_d = ST_RD_CAP;
        end else if (status_i.i_zero) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_LCG;
        end
      end
      ST_RD_CAP: begin
        cmd_o.cap_b = 1'b1;
        state_d = ST_FINISH;
      end
      ST_LCG: begin
        cmd_o.lcg_step = 1'b1;
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.rem_done) state_d = ST_RD_I;
      end
      ST_RD_I: begin
        cmd_o.addr_sel = ASEL_I;
        cmd_o.rd_en    = 1'b1;
        state_d = ST_RD_J;
      end
      ST_RD_J: begin
        cmd_o.addr_sel = ASEL_J;
        cmd_o.rd_en    = 1'b1;
        cmd_o.cap_a    = 1'b1;
        state_d = ST_CAP_B;
      end
      ST_CAP_B: begin
        cmd_o.cap_b = 1'b1;
        state_d = ST_WR_I;
      end
      ST_WR_I: begin
        cmd_o.addr_sel = ASEL_I;
        cmd_o.wr_en    = 1'b1;
        state_d = ST_WR_J;
      end
      ST_WR_J: begin
        cmd_o.addr_sel = ASEL_J;
        cmd_o.wr_en    = 1'b1;
        cmd_o.dec_i    = 1'b1;
        state_d = status_i.i_one ? ST_FINISH : ST_LCG;
      end
      ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

FILE: dv/lfys_perm_tracker.sv
// Permutation tracker for the LCG Fisher-Yates shuffler testbench: keeps its own
// permutation store, generator state and entry count, predicts each output word.
// Depends on lfys_pkg; instantiated beside the core by lcg_fisher_yates_shuffler_core_tb.
`timescale 1ns / 1ps

module lfys_perm_tracker
  import lfys_pkg::*;
#(
  parameter int unsigned DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_t                in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_t               out_data_i,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  output int unsigned        open_words_o,
  output int unsigned        err_count_o
);

  logic [ENTRY_W-1:0] perm_q [DEPTH];
  logic [SEED_W-1:0]  lcg_q;
  logic [COUNT_W-1:0] count_q;
  out_t               reply_q [$];
  out_t               want;

  task automatic report_mismatch(input string msg);
    $display("[%0t ns] mismatch: %s", $time, msg);
    err_count_o++;
  endtask

  // Run count-1 swap passes, the count clamped to the store depth.
  function automatic void shuffle_store(input logic [SEED_W-1:0] seed);
    int unsigned        n;
    int unsigned        j;
    logic [ENTRY_W-1:0] held;
    lcg_q = seed;
    n = (32'(count_q) > DEPTH) ? DEPTH : 32'(count_q);
    if (n < 2) return;
    for (int unsigned i = n - 1; i > 0; i--) begin
      lcg_q = lcg_q * LCG_MUL + LCG_ADD;
      j = lcg_q % (i + 1);
      held = perm_q[i];
      perm_q[i] = perm_q[j];
      perm_q[j] = held;
    end
  endfunction

  function automatic out_t predict_reply(input in_t w);
    out_t r;
    if (w.action == ACT_SHUFFLE) begin
      shuffle_store(w.seed);
      r.kind = KIND_SHUFFLE;
      r.entry_value = '0;
    end else begin
      r.kind = KIND_READ;
      r.entry_value = (w.position < DEPTH) ? perm_q[w.position] : '0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) perm_q[k] = ENTRY_W'(k);
      lcg_q = '0;
      count_q = COUNT_RESET;
      reply_q.delete();
      open_words_o = 0;
    end else begin
      if (cfg_we_i) begin
        count_q = cfg_wdata_i;
      end
      // Retire the output word first: it always belongs to an older input word.
      if (out_valid_i && out_ready_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("word with nothing expected, kind %0d value %0d",
                                    out_data_i.kind, out_data_i.entry_value));
        end else begin
          want = reply_q.pop_front();
          if (out_data_i.kind !== want.kind) begin
            report_mismatch($sformatf("kind got %0d expected %0d",
                                      out_data_i.kind, want.kind));
          end
          if (out_data_i.entry_value !== want.entry_value) begin
            report_mismatch($sformatf("entry_value got %0d expected %0d",
                                      out_data_i.entry_value, want.entry_value));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        reply_q.push_back(predict_reply(in_data_i));
      end
      open_words_o = reply_q.size();
    end
  end

endmodule

FILE: dv/lcg_fisher_yates_shuffler_core_tb.sv
// Testbench top for lcg_fisher_yates_shuffler_core: drives shuffle and read words,
// writes entry_count between phases, and prints the verdict.
// Depends on lfys_pkg, the core RTL and dv/lfys_perm_tracker.sv.
`timescale 1ns / 1ps

module lcg_fisher_yates_shuffler_core_tb;
  import lfys_pkg::*;

  localparam int unsigned DEPTH         = 4096;
  localparam int unsigned WORDS_PER_RUN = 20;   // random words in each random phase
  localparam int unsigned SHUFFLE_PCT   = 40;
  localparam int unsigned CFG_SETTLE    = 4;    // cycles of quiet before a count write
  localparam int unsigned DRAIN_CYCLES  = 16;   // margin after the last word is returned
  // The budget covers two full-depth shuffles, the small ones far cheaper,
  // before declaring a hang.
  localparam longint unsigned TIMEOUT_NS = 80_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_t               out_data_o;
  logic               cfg_we_i;
  logic [COUNT_W-1:0] cfg_wdata_i;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned entry_count    = 32'(COUNT_RESET);
  int unsigned open_words;
  int unsigned err_count;

  always #10 clk_i = ~clk_i;

  lcg_fisher_yates_shuffler_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  lfys_perm_tracker #(
    .DEPTH(DEPTH)
  ) i_perm_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .open_words_o(open_words),
    .err_count_o (err_count)
  );

  // Receiver: stall the output channel at the rate the current phase asks for.
  // A fresh draw every falling edge lets stalls land on any cycle of the core's work.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Offer one word at a falling edge, hold it until the core takes it, then drop
  // valid. A back-to-back caller raises valid again in the same time step, which
  // the core never sees since it samples only at the rising edge.
  task automatic send_word(input logic action, input logic [SEED_W-1:0] seed,
                           input logic [11:0] position);
    in_t w;
    w.action   = action;
    w.seed     = seed;
    w.position = position;
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = w;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Write entry_count only once the core has returned every word it took;
  // the short settle lets its controller walk back to idle.
  task automatic write_count(input logic [COUNT_W-1:0] value);
    while (open_words != 0) @(negedge clk_i);
    repeat (CFG_SETTLE) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    entry_count = 32'(value);
  endtask

  // Mix shuffles with reads; half the reads land inside the shuffled span,
  // where the permutation actually moves, the rest anywhere in the store.
  // Unused fields still carry random bits.
  task automatic send_random_word();
    int unsigned span;
    int unsigned position;
    span     = (entry_count > DEPTH) ? DEPTH : entry_count;
    position = $urandom_range(0, 4095);
    if ($urandom_range(0, 99) < SHUFFLE_PCT) begin
      send_word(ACT_SHUFFLE, $urandom(), position[11:0]);
    end else begin
      if (span > 0 && $urandom_range(0, 1) == 1) begin
        position = $urandom_range(0, span - 1);
      end
      send_word(ACT_READ, $urandom(), position[11:0]);
    end
  endtask

  initial begin
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words, no idling. The first read also waits out the clearing
    // sweep, since in_ready_o stays low until the store holds the identity.
    send_word(ACT_READ, 32'h0, 12'd0);
    send_word(ACT_READ, 32'h0, 12'd4095);

    // Count of zero: no swap passes, store left as is.
    write_count(13'd0);
    send_word(ACT_SHUFFLE, 32'hFFFF_FFFF, 12'd0);
    send_word(ACT_READ, 32'h0, 12'd1);

    // Count of one: still no swap passes.
    write_count(13'd1);
    send_word(ACT_SHUFFLE, 32'h0, 12'hFFF);
    send_word(ACT_READ, 32'h0, 12'd0);

    // Smallest count that swaps: a single pass over entries 0 and 1.
    write_count(13'd2);
    send_word(ACT_SHUFFLE, 32'h0, 12'd0);
    send_word(ACT_READ, 32'h0, 12'd0);
    send_word(ACT_READ, 32'h0, 12'd1);

    // Count above the depth: clamp to the full store.
    write_count(13'h1FFF);
    send_word(ACT_SHUFFLE, 32'hA5A5_5A5A, 12'd0);
    send_word(ACT_READ, 32'h0, 12'd0);
    send_word(ACT_READ, 32'h0, 12'd4095);
    send_word(ACT_READ, 32'h0, 12'd2048);

    // Full depth, building on the previous permutation.
    write_count(13'd4096);
    send_word(ACT_SHUFFLE, 32'h0, 12'd0);
    send_word(ACT_READ, 32'h0, 12'd0);
    send_word(ACT_READ, 32'h0, 12'd4095);

    // Count of three; reads at and above the count return the stored entry untouched.
    write_count(13'd3);
    send_word(ACT_SHUFFLE, 32'h8000_0001, 12'd0);
    send_word(ACT_READ, 32'h0, 12'd2);
    send_word(ACT_READ, 32'h0, 12'd3);
    send_word(ACT_READ, 32'h0, 12'd4095);

    // Random phases: no idling, sender idle, receiver stalling, both.
    // Keep counts small so each shuffle stays short.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 82;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 82;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      write_count(COUNT_W'((phase == 0) ? $urandom_range(33, 64) : $urandom_range(2, 32)));
      repeat (WORDS_PER_RUN) send_random_word();
    end

    // Drain: wait for every expected word, then let the core settle.
    while (open_words != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hang guard: a lost word or a stuck handshake ends the run here.
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
